// File: sv/fsd1_pkg.sv
// Package for the 1-bpp Floyd-Steinberg dither: word types, register indexes,
// error type and the share helper. Used by the top level and the checker.
// No dependencies.
package fsd1_pkg;

    // Input word: one grayscale sample
    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_last;
    } t_in_word;

    // Output word: eight packed pixels, 1 = black
    typedef struct packed {
        logic [7:0] packed_byte;
        logic       last_byte;
    } t_out_word;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH = 2'd0,
        REG_THRESHOLD   = 2'd1
    } t_cfg_reg;

    localparam logic [9:0] RESET_IMAGE_WIDTH = 10'd128;
    localparam logic [7:0] RESET_THRESHOLD   = 8'd128;
    localparam logic [7:0] PIXEL_MAX         = 8'd255;

    // Diffusion weights in sixteenths
    localparam logic [2:0] W_RIGHT = 3'd7;
    localparam logic [2:0] W_BL    = 3'd3;
    localparam logic [2:0] W_B     = 3'd5;
    localparam logic [2:0] W_BR    = 3'd1;

    // Carried error, stays within -254..255
    typedef logic signed [8:0] t_err;

    // (e * k) / 16 with truncation toward zero
    function automatic t_err share(input t_err e, input logic [2:0] k);
        logic signed [12:0] p;
        p = $signed({{4{e[8]}}, e}) * $signed({10'd0, k});
        if (p < 0) begin
            p = p + 13'sd15;
        end
        return t_err'(p >>> 4);
    endfunction

endpackage

// File: sv/floyd_steinberg_dither_1bpp.sv
// Top level of the 1-bpp Floyd-Steinberg dither with the row error memory.
// Depends on fsd1_pkg.
//
// Takes one 8-bit pixel per clock in raster order and returns one packed byte
// for every eight pixels and at the last pixel of a frame. A pixel is
// registered on acceptance, its error sum, clamp, threshold and shares are
// worked out from that register, and the byte it completes lands in the output
// register when the pixel fires. The block sustains one pixel per cycle; it
// holds off input only while a finished byte waits in the output register
// under stall and the pixel in hand would produce another. The next-row errors
// live in a MAX_WIDTH-deep memory with one write and one registered read port;
// every write goes through a two-entry write queue whose head drains into the
// memory whenever the processing stage is empty or fires. A fill mark tracks
// which columns the current frame has written, so no clearing pass is needed
// after reset or between frames. image_width and threshold are to be written
// through the configuration port between words only, not enforced by the block.
module floyd_steinberg_dither_1bpp #(
    parameter int MAX_WIDTH = 512
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // pixel words
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  fsd1_pkg::t_in_word               i_in_word,
    // packed byte words
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output fsd1_pkg::t_out_word              o_out_word,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fsd1_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fsd1_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int WW     = (ADDR_W + 1 > 10) ? ADDR_W + 1 : 10;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        fsd1_pkg::t_err    data;
    } t_qent;

    // Configuration registers
    logic [9:0] r_image_width;
    logic [7:0] r_threshold;

    // Issue side
    logic [ADDR_W-1:0] r_col, n_col;
    logic [WW-1:0]     w_eff, width_ext;
    logic              issue_row_end;
    logic              accept;

    // Processing stage
    logic                r_p_valid;
    logic [7:0]          r_p_pixel;
    logic                r_p_last;
    logic [ADDR_W-1:0]   r_p_col;
    logic                r_p_row_end;
    logic                p_fire;
    logic                p_emit;

    // Error state
    fsd1_pkg::t_err r_right, r_pend_below, r_pend_diag;
    logic [2:0]     r_bitpos;
    logic [7:0]     r_acc;
    logic [ADDR_W:0] r_fill, n_fill;

    // Row memory and write queue
    fsd1_pkg::t_err     mem [MAX_WIDTH];
    fsd1_pkg::t_err     r_rdq;
    t_qent              r_q [2];
    t_qent              n_q [2];
    logic [1:0]         r_qcnt, n_qcnt;
    logic               q_pop;
    t_qent              base0;
    logic [1:0]         cnt1;
    t_qent              push_a, push_b;
    t_qent              pl [2];
    logic               pa, pb;

    // Output register
    logic                r_out_valid;
    fsd1_pkg::t_out_word r_out;
    logic                out_free;

    // Datapath
    fsd1_pkg::t_err     below_in, below, below_left;
    fsd1_pkg::t_err     err, s1, s3, s5, s7;
    logic signed [10:0] sum;
    logic [7:0]         val;
    logic               white;
    logic [7:0]         acc_new;
    logic               col_nz;

    assign o_cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= fsd1_pkg::RESET_IMAGE_WIDTH;
            r_threshold   <= fsd1_pkg::RESET_THRESHOLD;
        end else if (i_cfg_valid) begin
            case (fsd1_pkg::t_cfg_reg'(i_cfg_index))
                fsd1_pkg::REG_IMAGE_WIDTH: r_image_width <= i_cfg_data[9:0];
                fsd1_pkg::REG_THRESHOLD:   r_threshold   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Effective width: zero means one, saturate at the row memory depth
    always_comb begin
        width_ext = WW'(r_image_width);
        if (width_ext == '0) begin
            w_eff = WW'(1);
        end else if (width_ext > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = width_ext;
        end
    end

    // Handshakes
    assign out_free   = !r_out_valid || !i_out_stall;
    assign p_emit     = (r_bitpos == 3'd7) || r_p_last;
    assign p_fire     = r_p_valid && (!p_emit || out_free);
    assign o_in_stall = r_p_valid && !p_fire;
    assign accept     = i_in_valid && !o_in_stall;

    // Advance the issue column; it depends on position, width and frame_last only
    assign issue_row_end = (WW'(r_col) + WW'(1)) >= w_eff;
    always_comb begin
        if (i_in_word.frame_last || issue_row_end) begin
            n_col = '0;
        end else begin
            n_col = r_col + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (accept) begin
            r_col <= n_col;
        end
    end

    // Load the processing stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (accept) begin
            r_p_valid <= 1'b1;
        end else if (p_fire) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_pixel   <= i_in_word.pixel;
            r_p_last    <= i_in_word.frame_last;
            r_p_col     <= r_col;
            r_p_row_end <= issue_row_end;
        end
    end

    // Row memory: drain the queue head, read at accept with write-first bypass
    assign q_pop = (r_qcnt != 2'd0) && (!r_p_valid || p_fire);

    always_ff @(posedge i_clk) begin
        if (q_pop) begin
            mem[r_q[0].addr] <= r_q[0].data;
        end
        if (accept) begin
            if (q_pop && (r_q[0].addr == r_col)) begin
                r_rdq <= r_q[0].data;
            end else begin
                r_rdq <= mem[r_col];
            end
        end
    end

    // Fetch the error below: newest queued entry first, then memory if filled
    always_comb begin
        if (r_qcnt == 2'd2 && r_q[1].addr == r_p_col) begin
            below_in = r_q[1].data;
        end else if (r_qcnt != 2'd0 && r_q[0].addr == r_p_col) begin
            below_in = r_q[0].data;
        end else if ((ADDR_W + 1)'(r_p_col) < r_fill) begin
            below_in = r_rdq;
        end else begin
            below_in = '0;
        end
    end

    // Add, clamp, threshold and split the error
    always_comb begin
        sum = $signed({3'd0, r_p_pixel}) + 11'(below_in) + 11'(r_right);
        if (sum < 0) begin
            val = 8'd0;
        end else if (sum > $signed({3'd0, fsd1_pkg::PIXEL_MAX})) begin
            val = fsd1_pkg::PIXEL_MAX;
        end else begin
            val = sum[7:0];
        end
        white = val > r_threshold;
        if (white) begin
            err = $signed({1'b0, val}) - $signed({1'b0, fsd1_pkg::PIXEL_MAX});
        end else begin
            err = $signed({1'b0, val});
        end
        s1 = fsd1_pkg::share(err, fsd1_pkg::W_BR);
        s3 = fsd1_pkg::share(err, fsd1_pkg::W_BL);
        s5 = fsd1_pkg::share(err, fsd1_pkg::W_B);
        s7 = fsd1_pkg::share(err, fsd1_pkg::W_RIGHT);
        col_nz     = r_p_col != '0;
        below_left = r_pend_below + s3;
        below      = s5 + (col_nz ? r_pend_diag : fsd1_pkg::t_err'(0));
        acc_new    = r_acc | (white ? 8'd0 : (8'h80 >> r_bitpos));
    end

    // Build the queue: pop the head, then append the finished entries
    always_comb begin
        pa          = p_fire && col_nz;
        pb          = p_fire && r_p_row_end;
        push_a.addr = r_p_col - ADDR_W'(1);
        push_a.data = below_left;
        push_b.addr = r_p_col;
        push_b.data = below;
        pl[0]       = pa ? push_a : push_b;
        pl[1]       = push_b;
        base0       = q_pop ? r_q[1] : r_q[0];
        cnt1        = r_qcnt - {1'b0, q_pop};
        n_q[0]      = (cnt1 != 2'd0) ? base0 : pl[0];
        if (cnt1 == 2'd2) begin
            n_q[1] = r_q[1];
        end else if (cnt1 == 2'd1) begin
            n_q[1] = pl[0];
        end else begin
            n_q[1] = pl[1];
        end
        n_qcnt = cnt1 + {1'b0, pa} + {1'b0, pb};
        // fill mark covers every column written in this frame
        n_fill = r_fill;
        if (pb && ((ADDR_W + 1)'(r_p_col) + (ADDR_W + 1)'(1) > r_fill)) begin
            n_fill = (ADDR_W + 1)'(r_p_col) + (ADDR_W + 1)'(1);
        end else if (pa && ((ADDR_W + 1)'(r_p_col) > r_fill)) begin
            n_fill = (ADDR_W + 1)'(r_p_col);
        end
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

    // Update error state; drop everything at the end of a frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcnt       <= '0;
            r_fill       <= '0;
            r_right      <= '0;
            r_pend_below <= '0;
            r_pend_diag  <= '0;
            r_bitpos     <= '0;
            r_acc        <= '0;
        end else if (p_fire && r_p_last) begin
            r_qcnt       <= '0;
            r_fill       <= '0;
            r_right      <= '0;
            r_pend_below <= '0;
            r_pend_diag  <= '0;
            r_bitpos     <= '0;
            r_acc        <= '0;
        end else begin
            r_qcnt <= n_qcnt;
            r_fill <= n_fill;
            if (p_fire) begin
                if (r_p_row_end) begin
                    r_right      <= '0;
                    r_pend_below <= '0;
                    r_pend_diag  <= '0;
                end else begin
                    r_right      <= s7;
                    r_pend_below <= below;
                    r_pend_diag  <= s1;
                end
                if (p_emit) begin
                    r_bitpos <= '0;
                    r_acc    <= '0;
                end else begin
                    r_bitpos <= r_bitpos + 3'd1;
                    r_acc    <= acc_new;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (p_fire && p_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_fire && p_emit) begin
            r_out.packed_byte <= acc_new;
            r_out.last_byte   <= r_p_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// File: sv/fsd1_chk.sv
// Port-level checker for the 1-bpp dither and its bind to the top level.
// Depends on fsd1_pkg and floyd_steinberg_dither_1bpp.
module fsd1_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input fsd1_pkg::t_in_word  i_in_word,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input fsd1_pkg::t_out_word o_out_word,
    input logic                o_cfg_ready
);

    // A stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed under stall");

    // Input never backs up while the output register is empty
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output register");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid after reset");

    // Configuration writes are not refused after an accepted pixel
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind floyd_steinberg_dither_1bpp fsd1_chk u_fsd1_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word),
    .o_cfg_ready (o_cfg_ready)
);
